// ===== rtl/tscf_pkg.sv =====
// Shared types, constants and character helper functions of the text stream filter.
package tscf_pkg;

  localparam int unsigned NumberDigits = 6;
  localparam int unsigned BcdW         = 4 * NumberDigits;
  localparam int unsigned MaxChars     = 4;
  localparam int unsigned CharCntW     = 3;
  localparam int unsigned PosW         = $clog2(NumberDigits + 6);
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned PtrW         = $clog2(QueueDepth);

  localparam logic [2:0] ModePlain    = 3'd0;
  localparam logic [2:0] ModeNumNb    = 3'd1;
  localparam logic [2:0] ModeShowEnds = 3'd2;
  localparam logic [2:0] ModeNumAll   = 3'd3;
  localparam logic [2:0] ModeSqueeze  = 3'd4;
  localparam logic [2:0] ModeShowTabs = 3'd5;

  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharNl     = 8'h0A;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharDash   = 8'h2D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharQuery  = 8'h3F;
  localparam logic [7:0] CharM      = 8'h4D;
  localparam logic [7:0] CharCaret  = 8'h5E;
  localparam logic [7:0] CharDel    = 8'h7F;
  localparam logic [7:0] CharMaxHi  = 8'hFF;

  localparam logic [1:0] RunMax = 2'd3;

  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CharCntW-1:0]      n_chars;
  } vis_t;

  typedef struct packed {
    logic                     num_en;
    logic [BcdW-1:0]          bcd;
    logic [MaxChars-1:0][7:0] chars;
    logic [CharCntW-1:0]      n_chars;
  } desc_t;

  // Saturating BCD increment: all nines hold their value.
  function automatic logic [BcdW-1:0] bcd_inc(input logic [BcdW-1:0] v);
    logic [BcdW-1:0] r;
    logic            carry;
    logic            all9;
    r     = v;
    carry = 1'b1;
    all9  = 1'b1;
    for (int i = 0; i < NumberDigits; i++) begin
      if (v[4*i +: 4] != 4'd9) all9 = 1'b0;
    end
    for (int i = 0; i < NumberDigits; i++) begin
      if (carry) begin
        if (r[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = r[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    if (all9) r = v;
    return r;
  endfunction

  // Character for one column of the line number; leading zeros become spaces.
  function automatic logic [7:0] digit_char(input logic [BcdW-1:0] bcd, input int unsigned d);
    logic seen;
    seen = (d == 0);
    for (int unsigned i = 0; i < NumberDigits; i++) begin
      if (i >= d && bcd[4*i +: 4] != 4'd0) seen = 1'b1;
    end
    return seen ? (CharZero + {4'd0, bcd[4*d +: 4]}) : CharSpace;
  endfunction

  // Caret and M- notation of one byte; unless tabs are shown, a tab stays and a newline gets a $.
  function automatic vis_t visible(input logic [7:0] c, input logic tabs_visible);
    vis_t v;
    v.chars   = '0;
    v.n_chars = CharCntW'(1);
    if (c >= CharSpace && c < CharDel) begin
      v.chars[0] = c;
    end else if (c == CharDel) begin
      v.chars[0] = CharCaret;
      v.chars[1] = CharQuery;
      v.n_chars  = CharCntW'(2);
    end else if (c == CharMaxHi) begin
      v.chars   = {CharQuery, CharCaret, CharDash, CharM};
      v.n_chars = CharCntW'(4);
    end else if (c >= 8'd160) begin
      v.chars[0] = CharM;
      v.chars[1] = CharDash;
      v.chars[2] = c - 8'd128;
      v.n_chars  = CharCntW'(3);
    end else if (c >= 8'd128) begin
      v.chars   = {c - 8'd64, CharCaret, CharDash, CharM};
      v.n_chars = CharCntW'(4);
    end else if (c == CharTab && !tabs_visible) begin
      v.chars[0] = CharTab;
    end else if (c == CharNl) begin
      if (tabs_visible) begin
        v.chars[0] = CharNl;
      end else begin
        v.chars[0] = CharDollar;
        v.chars[1] = CharNl;
        v.n_chars  = CharCntW'(2);
      end
    end else begin
      v.chars[0] = CharCaret;
      v.chars[1] = c + 8'd64;
      v.n_chars  = CharCntW'(2);
    end
    return v;
  endfunction

endpackage

// ===== rtl/tscf_front.sv =====
// Front end: mode register, line state and classification of each input byte.
module tscf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 file_start_i,
  input  logic                 full_i,
  output logic                 push_o,
  output tscf_pkg::desc_t      desc_o
);

  logic [2:0]                mode_q;
  logic [tscf_pkg::BcdW-1:0] line_q, line_d;
  logic                      prev_nl_q, prev_nl_d;
  logic [1:0]                run_q, run_d, run_base;
  logic                      accept;
  logic                      nl;
  logic                      number;
  logic                      emit;
  tscf_pkg::vis_t            vis;

  assign accept = in_valid_i && !full_i;
  assign nl     = (in_byte_i == tscf_pkg::CharNl);
  assign run_base = file_start_i ? 2'd0 : run_q;
  assign vis    = tscf_pkg::visible(in_byte_i, mode_q == tscf_pkg::ModeShowTabs);

  always_comb begin
    line_d         = line_q;
    prev_nl_d      = prev_nl_q;
    run_d          = run_base;
    number         = 1'b0;
    emit           = 1'b1;
    desc_o.num_en  = 1'b0;
    desc_o.bcd     = line_q;
    desc_o.chars   = '0;
    desc_o.chars[0] = in_byte_i;
    desc_o.n_chars = tscf_pkg::CharCntW'(1);
    unique case (mode_q) inside
      tscf_pkg::ModeNumNb, tscf_pkg::ModeNumAll: begin
        number        = prev_nl_q && (mode_q == tscf_pkg::ModeNumAll || !nl);
        prev_nl_d     = nl;
        desc_o.num_en = number;
        if (number) line_d = tscf_pkg::bcd_inc(line_q);
      end
      tscf_pkg::ModeShowEnds, tscf_pkg::ModeShowTabs: begin
        desc_o.chars   = vis.chars;
        desc_o.n_chars = vis.n_chars;
      end
      tscf_pkg::ModeSqueeze: begin
        if (nl) begin
          run_d = (run_base == tscf_pkg::RunMax) ? tscf_pkg::RunMax : run_base + 2'd1;
        end else begin
          run_d = 2'd0;
        end
        emit = (run_d != tscf_pkg::RunMax);
      end
      default: begin
      end
    endcase
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= tscf_pkg::ModePlain;
      line_q    <= tscf_pkg::BcdW'(1);
      prev_nl_q <= 1'b1;
      run_q     <= 2'd0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (accept) begin
        line_q    <= line_d;
        prev_nl_q <= prev_nl_d;
        run_q     <= run_d;
      end
    end
  end

endmodule

// ===== rtl/tscf_fifo.sv =====
// Short descriptor queue between the front end and the character emitter.
module tscf_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tscf_pkg::desc_t      push_desc_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output tscf_pkg::desc_t      head_o
);

  tscf_pkg::desc_t              mem_q [tscf_pkg::QueueDepth];
  logic [tscf_pkg::PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [tscf_pkg::PtrW:0]      cnt_q;

  assign full_o  = (cnt_q == (tscf_pkg::PtrW+1)'(tscf_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (tscf_pkg::PtrW+1)'(tscf_pkg::QueueDepth))
    else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
`endif

endmodule

// ===== rtl/tscf_back.sv =====
// Back end: walks descriptors, one character per cycle to the output register when not stalled.
module tscf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  tscf_pkg::desc_t      head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_char_o,
  output logic                 last_of_run_o
);

  logic [tscf_pkg::PosW-1:0] pos_q, pos_d;
  logic [tscf_pkg::PosW-1:0] off, total, rel;
  logic                      is_last;
  logic                      load;
  logic [7:0]                ch;
  logic                      out_valid_q;
  logic [7:0]                out_char_q;
  logic                      out_last_q;

  assign off     = head_i.num_en ? tscf_pkg::PosW'(tscf_pkg::NumberDigits + 1) : '0;
  assign total   = off + tscf_pkg::PosW'(head_i.n_chars);
  assign rel     = pos_q - off;
  assign is_last = (pos_q == total - 1'b1);
  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = load && is_last;

  always_comb begin
    ch = head_i.chars[rel[1:0]];
    if (head_i.num_en) begin
      for (int unsigned k = 0; k < tscf_pkg::NumberDigits; k++) begin
        if (pos_q == tscf_pkg::PosW'(k)) begin
          ch = tscf_pkg::digit_char(head_i.bcd, tscf_pkg::NumberDigits - 1 - k);
        end
      end
      if (pos_q == tscf_pkg::PosW'(tscf_pkg::NumberDigits)) ch = tscf_pkg::CharTab;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (load) pos_d = is_last ? '0 : pos_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (!out_valid_q || !out_stall_i) out_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= ch;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_of_run_o = out_last_q;

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (pos_q < total))
    else $error("character position beyond descriptor length");
  a_pos_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (pos_q == '0))
    else $error("position left over without a queued descriptor");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=>
      (out_valid_q && $stable(out_char_q) && $stable(out_last_q)))
    else $error("stalled output transfer changed");
`endif

endmodule

// ===== rtl/text_stream_cat_filter.sv =====
// Top level of the text stream filter: front end, descriptor queue and character emitter.
// The first character of a byte passes through its queue entry and then the output register
// before it is presented. Throughput: one input byte per cycle while each byte yields one
// character and the output does not stall; an expanded byte holds the emitter for all of its
// characters at one per cycle, which then bounds the rate; the four-entry queue absorbs bursts.
// Reset clears the mode to plain copy, the line number to one, the newline flag to set, the
// newline run to zero and empties the queue; no clearing pass is needed.
module text_stream_cat_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       file_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_of_run_o
);

  // Handshake between the front end and the queue: a byte that produces
  // characters becomes one descriptor; a squeezed newline produces none.
  logic            push;
  logic            full;
  tscf_pkg::desc_t push_desc;

  // Queue head as seen by the emitter.
  logic            head_valid;
  tscf_pkg::desc_t head;
  logic            pop;

  // The input side stalls only when the queue is full, so it keeps taking
  // bytes while the output register still holds a character.
  assign in_stall_o = full;

  tscf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .file_start_i (file_start_i),
    .full_i       (full),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  tscf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .full_o      (full),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  // The emitter walks the line number columns, the tab and then the
  // character expansion of the byte, one transfer per cycle while the output is not stalled.
  tscf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
